// ===== src/msi_pkg.sv =====
// Package: shared constants, types and helpers of the servo interpolator.
`default_nettype none
package msi_pkg;
   localparam int LEG_CHANNELS = 8;
   localparam int FRAC_BITS    = 16;
   localparam int ANGLE_MAX    = 180;
   localparam int ANGLE_W      = 8;
   localparam int POS_W        = ANGLE_W + FRAC_BITS;
   localparam int INC_W        = POS_W + 1;
   localparam int DCNT_W       = $clog2(POS_W);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef logic [ANGLE_W-1:0] angle_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAX,
      S_CHK,
      S_DIV,
      S_WR,
      S_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic snap;
      logic tick;
      logic div_start;
      logic div_step;
      logic inc_write;
   } lane_cmd_type;

   // clamp an angle to the servo range
   function automatic angle_type sat_angle(input angle_type a);
      return (a > angle_type'(ANGLE_MAX)) ? angle_type'(ANGLE_MAX) : a;
   endfunction

   // setup posture: 80/100/100/80 repeating by channel
   function automatic angle_type posture(input int idx);
      return ((idx % 4 == 0) || (idx % 4 == 3)) ? sat_angle(angle_type'(80))
                                                : sat_angle(angle_type'(100));
   endfunction
endpackage
`default_nettype wire

// ===== src/msi_if.sv =====
// Interfaces: request and response channels of the servo interpolator.
`default_nettype none
interface msi_req_if;
   logic                 valid;
   logic                 ready;
   logic                 opcode;
   msi_pkg::angle_type   target_0;
   msi_pkg::angle_type   target_1;
   msi_pkg::angle_type   target_2;
   msi_pkg::angle_type   target_3;
   msi_pkg::angle_type   target_4;
   msi_pkg::angle_type   target_5;
   msi_pkg::angle_type   target_6;
   msi_pkg::angle_type   target_7;
   msi_pkg::angle_type   target_head;
   modport source (output valid, opcode, target_0, target_1, target_2, target_3,
                   target_4, target_5, target_6, target_7, target_head, input ready);
   modport sink   (input valid, opcode, target_0, target_1, target_2, target_3,
                   target_4, target_5, target_6, target_7, target_head, output ready);
endinterface

interface msi_rsp_if;
   logic                 valid;
   logic                 ready;
   msi_pkg::angle_type   angle_0;
   msi_pkg::angle_type   angle_1;
   msi_pkg::angle_type   angle_2;
   msi_pkg::angle_type   angle_3;
   msi_pkg::angle_type   angle_4;
   msi_pkg::angle_type   angle_5;
   msi_pkg::angle_type   angle_6;
   msi_pkg::angle_type   angle_7;
   msi_pkg::angle_type   angle_head;
   logic                 busy_res;
   modport source (output valid, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5,
                   angle_6, angle_7, angle_head, busy_res, input ready);
   modport sink   (input valid, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5,
                   angle_6, angle_7, angle_head, busy_res, output ready);
endinterface
`default_nettype wire

// ===== src/msi_lane.sv =====
// One leg lane: position, goal, increment and a bit-serial divider.
`default_nettype none
module msi_lane (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire msi_pkg::lane_cmd_type     cmd,
   input  wire msi_pkg::angle_type        target,
   input  wire msi_pkg::angle_type        reset_goal,
   input  wire msi_pkg::angle_type        divisor,
   output      msi_pkg::angle_type        mag,
   output      msi_pkg::angle_type        angle
);
   logic [msi_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [msi_pkg::INC_W-1:0]    inc_ff, inc_in;
   msi_pkg::angle_type           goal_ff, goal_in;
   logic [msi_pkg::POS_W-1:0]    num_ff, num_in;
   msi_pkg::angle_type           rem_ff, rem_in;
   logic                         neg_ff, neg_in;

   logic [msi_pkg::INC_W-1:0]    diff_raw;
   logic [msi_pkg::INC_W-1:0]    diff_abs;
   msi_pkg::angle_type           tgt_sat;
   logic [msi_pkg::ANGLE_W:0]    trial;
   logic                         qbit;

   // signed distance from present position to goal
   always_comb begin
      tgt_sat  = msi_pkg::sat_angle(target);
      diff_raw = {1'b0, goal_ff, {msi_pkg::FRAC_BITS{1'b0}}} - {1'b0, pos_ff};
      diff_abs = diff_raw[msi_pkg::INC_W-1] ? (~diff_raw + 1'b1) : diff_raw;
      mag      = diff_abs[msi_pkg::POS_W-1:msi_pkg::FRAC_BITS];
      angle    = pos_ff[msi_pkg::POS_W-1:msi_pkg::FRAC_BITS];
      trial    = {rem_ff, num_ff[msi_pkg::POS_W-1]};
      qbit     = (trial >= {1'b0, divisor});
   end

   // next state of the lane
   always_comb begin
      pos_in  = pos_ff;
      inc_in  = inc_ff;
      goal_in = goal_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      if (cmd.load) begin
         goal_in = tgt_sat;
      end
      if (cmd.load && cmd.snap) begin
         pos_in = {tgt_sat, {msi_pkg::FRAC_BITS{1'b0}}};
      end else if (cmd.snap) begin
         pos_in = {goal_ff, {msi_pkg::FRAC_BITS{1'b0}}};
      end else if (cmd.tick) begin
         pos_in = pos_ff + inc_ff[msi_pkg::POS_W-1:0];
      end
      if (cmd.div_start) begin
         num_in = diff_abs[msi_pkg::POS_W-1:0];
         rem_in = '0;
         neg_in = diff_raw[msi_pkg::INC_W-1];
      end else if (cmd.div_step) begin
         rem_in = qbit ? msi_pkg::angle_type'(trial - {1'b0, divisor})
                       : trial[msi_pkg::ANGLE_W-1:0];
         num_in = {num_ff[msi_pkg::POS_W-2:0], qbit};
      end
      if (cmd.inc_write) begin
         inc_in = neg_ff ? (~{1'b0, num_ff} + 1'b1) : {1'b0, num_ff};
      end
   end

   // lane registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= {reset_goal, {msi_pkg::FRAC_BITS{1'b0}}};
         inc_ff  <= '0;
         goal_ff <= reset_goal;
      end else begin
         pos_ff  <= pos_in;
         inc_ff  <= inc_in;
         goal_ff <= goal_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end
endmodule
`default_nettype wire

// ===== src/msi_merge.sv =====
// Merge stage: registered maximum of the lane distances.
`default_nettype none
module msi_merge (
   input  wire logic                                               clock,
   input  wire msi_pkg::angle_type [msi_pkg::LEG_CHANNELS-1:0]     mags,
   output      msi_pkg::angle_type                                 max_out
);
   msi_pkg::angle_type max_ff, max_in;

   // fold over the lanes
   always_comb begin
      max_in = '0;
      for (int i = 0; i < msi_pkg::LEG_CHANNELS; i++) begin
         if (mags[i] > max_in) begin
            max_in = mags[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in;
   end

   assign max_out = max_ff;
endmodule
`default_nettype wire

// ===== src/multi_axis_servo_interpolator_core.sv =====
// Top level: eight leg lanes, merge stage, sequencer, head channel, response register.
// A tick transfer steps the legs or the head, then loads the response register. A load
// transfer with smoothing on sets the goals, registers the maximum over the
// lanes, checks it, runs the lanes' bit-serial dividers (one quotient bit per
// cycle across all lanes at once), writes the increments and loads the response
// register. A load with smoothing off snaps the legs to their goals; one with no
// whole-degree leg distance snaps them after the check. A response
// waits in its register until it is taken.
`default_nettype none
module multi_axis_servo_interpolator_core (
   input  wire logic  clock,
   input  wire logic  reset,
   msi_req_if.sink    req_ch,
   msi_rsp_if.source  rsp_ch,
   input  wire logic  csr_we,
   input  wire logic  csr_wdata
);
   msi_pkg::state_type      state_ff, state_in;
   logic                    smooth_ff;
   msi_pkg::angle_type      steps_ff, steps_in;
   msi_pkg::angle_type      head_pos_ff, head_pos_in;
   msi_pkg::angle_type      head_goal_ff, head_goal_in;
   logic [msi_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   msi_pkg::angle_type [msi_pkg::LEG_CHANNELS-1:0] rsp_angle_ff;
   msi_pkg::angle_type      rsp_head_ff;
   logic                    rsp_busy_ff;

   msi_pkg::lane_cmd_type   cmd;
   msi_pkg::angle_type [msi_pkg::LEG_CHANNELS-1:0] targets;
   msi_pkg::angle_type [msi_pkg::LEG_CHANNELS-1:0] mags;
   msi_pkg::angle_type [msi_pkg::LEG_CHANNELS-1:0] angles;
   msi_pkg::angle_type      max_dist;
   logic                    acc;
   logic                    load_rsp;

   assign targets = {req_ch.target_7, req_ch.target_6, req_ch.target_5, req_ch.target_4,
                     req_ch.target_3, req_ch.target_2, req_ch.target_1, req_ch.target_0};

   // lanes
   for (genvar g = 0; g < msi_pkg::LEG_CHANNELS; g++) begin : g_lane
      msi_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .target     (targets[g]),
         .reset_goal (msi_pkg::posture(g)),
         .divisor    (max_dist),
         .mag        (mags[g]),
         .angle      (angles[g])
      );
   end

   msi_merge u_merge (
      .clock   (clock),
      .mags    (mags),
      .max_out (max_dist)
   );

   assign req_ch.ready = (state_ff == msi_pkg::S_IDLE);
   assign acc          = req_ch.valid && req_ch.ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      steps_in     = steps_ff;
      head_pos_in  = head_pos_ff;
      head_goal_in = head_goal_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         msi_pkg::S_IDLE: begin
            if (acc && req_ch.opcode == msi_pkg::OP_LOAD) begin
               cmd.load     = 1'b1;
               head_goal_in = msi_pkg::sat_angle(req_ch.target_head);
               if (!smooth_ff) begin
                  cmd.snap    = 1'b1;
                  steps_in    = '0;
                  head_pos_in = msi_pkg::sat_angle(req_ch.target_head);
                  state_in    = msi_pkg::S_OUT;
               end else begin
                  state_in = msi_pkg::S_MAX;
               end
            end else if (acc) begin
               if (steps_ff != '0) begin
                  cmd.tick = 1'b1;
                  cmd.snap = (steps_ff == msi_pkg::angle_type'(1));
                  steps_in = steps_ff - 1'b1;
               end else if (head_pos_ff < head_goal_ff) begin
                  head_pos_in = head_pos_ff + 1'b1;
               end else if (head_pos_ff > head_goal_ff) begin
                  head_pos_in = head_pos_ff - 1'b1;
               end
               state_in = msi_pkg::S_OUT;
            end
         end
         msi_pkg::S_MAX: begin
            state_in = msi_pkg::S_CHK;
         end
         msi_pkg::S_CHK: begin
            if (max_dist == '0) begin
               cmd.snap = 1'b1;
               steps_in = '0;
               state_in = msi_pkg::S_OUT;
            end else begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = msi_pkg::S_DIV;
            end
         end
         msi_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == msi_pkg::DCNT_W'(msi_pkg::POS_W - 1)) begin
               state_in = msi_pkg::S_WR;
            end
         end
         msi_pkg::S_WR: begin
            cmd.inc_write = 1'b1;
            steps_in      = max_dist;
            state_in      = msi_pkg::S_OUT;
         end
         msi_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = msi_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = msi_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msi_pkg::S_IDLE;
         smooth_ff    <= 1'b1;
         steps_ff     <= '0;
         head_pos_ff  <= msi_pkg::sat_angle(msi_pkg::angle_type'(90));
         head_goal_ff <= msi_pkg::sat_angle(msi_pkg::angle_type'(90));
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         steps_ff     <= steps_in;
         head_pos_ff  <= head_pos_in;
         head_goal_ff <= head_goal_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            smooth_ff <= csr_wdata;
         end
      end
      cnt_ff <= cnt_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_angle_ff <= angles;
         rsp_head_ff  <= head_pos_ff;
         rsp_busy_ff  <= (steps_ff != '0) || (head_pos_ff != head_goal_ff);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.angle_0    = rsp_angle_ff[0];
   assign rsp_ch.angle_1    = rsp_angle_ff[1];
   assign rsp_ch.angle_2    = rsp_angle_ff[2];
   assign rsp_ch.angle_3    = rsp_angle_ff[3];
   assign rsp_ch.angle_4    = rsp_angle_ff[4];
   assign rsp_ch.angle_5    = rsp_angle_ff[5];
   assign rsp_ch.angle_6    = rsp_angle_ff[6];
   assign rsp_ch.angle_7    = rsp_angle_ff[7];
   assign rsp_ch.angle_head = rsp_head_ff;
   assign rsp_ch.busy_res   = rsp_busy_ff;

   // checks
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msi_pkg::S_DIV) |-> (max_dist != '0))
      else $error("divider running with zero divisor");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (acc && req_ch.opcode == msi_pkg::OP_TICK && steps_ff == msi_pkg::angle_type'(1))
      |=> (steps_ff == '0))
      else $error("final tick did not end leg motion");

   a_head_waits: assert property (@(posedge clock) disable iff (reset)
      ((steps_ff != '0) && !(acc && req_ch.opcode == msi_pkg::OP_LOAD))
      |=> $stable(head_pos_ff))
      else $error("head moved while legs still in motion");
endmodule
`default_nettype wire
